// ----- rtl/core/keymap_layer_resolver_assert.svh -----
// ----------------------------------------------------------------------------
// keymap_layer_resolver_assert.svh
// Assertion macros shared by the keymap layer resolver RTL.
// ----------------------------------------------------------------------------
`ifndef KEYMAP_LAYER_RESOLVER_ASSERT_SVH
`define KEYMAP_LAYER_RESOLVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/klr_pkg.sv -----
// ----------------------------------------------------------------------------
// klr_pkg
// Shared widths, sizes and codes for the keymap layer resolver.
// ----------------------------------------------------------------------------
package klr_pkg;

  // keymap geometry
  localparam int LAYER_COUNT = 8;
  localparam int ROW_COUNT   = 8;
  localparam int COL_COUNT   = 16;
  localparam int DEPTH       = LAYER_COUNT * ROW_COUNT * COL_COUNT;
  localparam int LAYER_W     = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // field widths
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 16;
  localparam int TIME_W   = 32;
  localparam int LIDX_W   = 8;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 4;
  localparam int MASK_W   = 8;
  localparam int TOP_W    = 3;
  localparam int TAPC_W   = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;

  // layer command types (high byte of the keycode)
  localparam logic [7:0] TYPE_MO = 8'h51;
  localparam logic [7:0] TYPE_TG = 8'h52;
  localparam logic [7:0] TYPE_TO = 8'h53;
  localparam logic [7:0] TYPE_TT = 8'h54;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_TAP_TERM = 2'd0;
  localparam logic [1:0] REG_TRANSP   = 2'd1;
  localparam logic [1:0] REG_NO_KEY   = 2'd2;

  // reset values
  localparam logic [CODE_W-1:0] TAP_TERM_RESET = 16'd200;
  localparam logic [CODE_W-1:0] TRANSP_RESET   = 16'd1;
  localparam logic [CODE_W-1:0] NO_KEY_RESET   = 16'd0;
  localparam logic [MASK_W-1:0] MASK_RESET     = 8'h01;

endpackage

// ----- rtl/core/klr_in_if.sv -----
// ----------------------------------------------------------------------------
// klr_in_if
// Input channel: one layer event, lookup or keymap write per transaction.
// ----------------------------------------------------------------------------
interface klr_in_if;
  import klr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] key_code;
  logic              is_press;
  logic [TIME_W-1:0] now_ms;
  logic [LIDX_W-1:0] layer_index;
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  col_index;
  logic [CODE_W-1:0] entry_value;

  modport source (
    output valid, kind, key_code, is_press, now_ms, layer_index, row_index,
           col_index, entry_value,
    input  ready
  );

  modport sink (
    input  valid, kind, key_code, is_press, now_ms, layer_index, row_index,
           col_index, entry_value,
    output ready
  );

endinterface

// ----- rtl/core/klr_out_if.sv -----
// ----------------------------------------------------------------------------
// klr_out_if
// Result channel: one result per input transaction.
// ----------------------------------------------------------------------------
interface klr_out_if;
  import klr_pkg::*;

  logic              valid;
  logic              ready;
  logic              not_layer_key;
  logic [CODE_W-1:0] resolved_code;
  logic [MASK_W-1:0] active_mask;
  logic [TOP_W-1:0]  top_layer;

  modport source (
    output valid, not_layer_key, resolved_code, active_mask, top_layer,
    input  ready
  );

  modport sink (
    input  valid, not_layer_key, resolved_code, active_mask, top_layer,
    output ready
  );

endinterface

// ----- rtl/core/keymap_layer_resolver.sv -----
// ----------------------------------------------------------------------------
// keymap_layer_resolver
// Keyboard layer stack with transparent-key fall-through over a keymap RAM.
// ----------------------------------------------------------------------------
// Flow: one input transaction is in flight at a time. A layer event, a
// keymap write or an unused kind goes from acceptance straight to the
// result stage; a lookup first reads k keymap layers, where k is 0 for an
// out-of-range lookup, else 1 to LAYER_COUNT. The keymap is a single-port
// RAM with a registered read, so the transparent walk reads one layer per
// cycle; that port sets the lookup time. The result register is separate
// from the sequencer, so the next transaction is taken while a result
// still waits on the output. Layer 0 is always active. Configuration
// registers sit at byte addresses 0 (tapping term), 4 (transparent code)
// and 8 (no-key code); write them only while the block is idle. Keymap
// entries read back undefined until written. No clearing pass is run
// after reset.
// ----------------------------------------------------------------------------
module keymap_layer_resolver (
  input  logic                           clk,
  input  logic                           rst_n,
  klr_in_if.sink                         in_chan,
  klr_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [klr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [klr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [klr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import klr_pkg::*;

  `include "keymap_layer_resolver_assert.svh"

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a transaction
    S_READ = 3'b010,  // keymap read data valid, walk transparent entries
    S_DONE = 3'b100   // result held until the output register frees up
  } state_t;

  localparam logic [MASK_W-1:0] ALL_ONES = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0] tap_term_r;
  logic [CODE_W-1:0] transp_r;
  logic [CODE_W-1:0] no_key_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_term_r <= TAP_TERM_RESET;
      transp_r   <= TRANSP_RESET;
      no_key_r   <= NO_KEY_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TAP_TERM: tap_term_r <= pwdata[CODE_W-1:0];
        REG_TRANSP:   transp_r   <= pwdata[CODE_W-1:0];
        REG_NO_KEY:   no_key_r   <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TAP_TERM: prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, tap_term_r};
      REG_TRANSP:   prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, transp_r};
      REG_NO_KEY:   prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, no_key_r};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Keymap RAM: one port, registered read
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0] keymap_mem [DEPTH];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [CODE_W-1:0] mem_wdata;
  logic [CODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      keymap_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= keymap_mem[mem_addr];
    end
  end

  function automatic logic [ADDR_W-1:0] map_addr(logic [LAYER_W-1:0] lyr,
                                                 logic [ROW_W-1:0]   row,
                                                 logic [COL_W-1:0]   col);
    return ADDR_W'(32'(lyr) * (ROW_COUNT * COL_COUNT) + 32'(row) * COL_COUNT
                   + 32'(col));
  endfunction

  // highest set bit of a mask: {found, index}
  function automatic logic [TOP_W:0] highest(logic [MASK_W-1:0] m);
    logic [TOP_W-1:0] idx;
    logic             found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (m[i]) begin
        idx   = TOP_W'(i);
        found = 1'b1;
      end
    end
    return {found, idx};
  endfunction

  // --------------------------------------------------------------------------
  // Layer state and sequencer
  // --------------------------------------------------------------------------
  state_t             state_r,    state_nxt;
  logic [MASK_W-1:0]  layers_r,   layers_nxt;
  logic [TIME_W-1:0]  tap_time_r, tap_time_nxt;
  logic [TAPC_W-1:0]  tap_cnt_r,  tap_cnt_nxt;
  logic [LIDX_W-1:0]  tap_layer_r, tap_layer_nxt;
  logic [LAYER_W-1:0] cur_layer_r, cur_layer_nxt;
  logic [ROW_W-1:0]   row_r,      row_nxt;
  logic [COL_W-1:0]   col_r,      col_nxt;
  logic               res_pass_r, res_pass_nxt;
  logic [CODE_W-1:0]  res_code_r, res_code_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_pass_r,  out_pass_nxt;
  logic [CODE_W-1:0]  out_code_r,  out_code_nxt;
  logic [MASK_W-1:0]  out_mask_r,  out_mask_nxt;
  logic [TOP_W-1:0]   out_top_r,   out_top_nxt;

  logic               in_take;
  logic               addr_ok;
  logic [LAYER_W-1:0] in_layer;

  // layer event decode
  logic [7:0]         ev_type;
  logic [LIDX_W-1:0]  ev_layer;
  logic [MASK_W-1:0]  ev_bit;      // one-hot of the layer, zero if out of range
  logic [MASK_W-1:0]  ev_bit_nz;   // same, zero also for layer 0
  logic [TIME_W-1:0]  elapsed;
  logic               tap_hit;
  logic [TAPC_W-1:0]  tap_cnt_inc;

  // transparent walk
  logic [MASK_W-1:0]  below_mask;
  logic [TOP_W:0]     below_hi;
  logic [TOP_W:0]     top_hi;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;

  assign addr_ok  = (32'(in_chan.layer_index) < LAYER_COUNT) &&
                    (32'(in_chan.row_index) < ROW_COUNT) &&
                    (32'(in_chan.col_index) < COL_COUNT);
  assign in_layer = LAYER_W'(in_chan.layer_index);

  assign ev_type     = in_chan.key_code[15:8];
  assign ev_layer    = in_chan.key_code[7:0];
  assign ev_bit      = (32'(ev_layer) < LAYER_COUNT) ?
                       (MASK_W'(1) << ev_layer[TOP_W-1:0]) : '0;
  assign ev_bit_nz   = (ev_layer != '0) ? ev_bit : '0;
  assign elapsed     = in_chan.now_ms - tap_time_r;  // wraps mod 2^32
  assign tap_hit     = (elapsed < TIME_W'(tap_term_r)) && (tap_layer_r == ev_layer);
  assign tap_cnt_inc = tap_cnt_r + TAPC_W'(1);

  // active layers strictly below the one just read
  assign below_mask = layers_r & ~(ALL_ONES << cur_layer_r);
  assign below_hi   = highest(below_mask);
  assign top_hi     = highest(layers_r);

  always_comb begin
    state_nxt     = state_r;
    layers_nxt    = layers_r;
    tap_time_nxt  = tap_time_r;
    tap_cnt_nxt   = tap_cnt_r;
    tap_layer_nxt = tap_layer_r;
    cur_layer_nxt = cur_layer_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_pass_nxt  = res_pass_r;
    res_code_nxt  = res_code_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = map_addr(in_layer, in_chan.row_index, in_chan.col_index);
    mem_wdata     = in_chan.entry_value;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pass_nxt  = out_pass_r;
    out_code_nxt  = out_code_r;
    out_mask_nxt  = out_mask_r;
    out_top_nxt   = out_top_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_pass_nxt = 1'b0;
          res_code_nxt = '0;
          state_nxt    = S_DONE;
          row_nxt      = in_chan.row_index;
          col_nxt      = in_chan.col_index;
          cur_layer_nxt = in_layer;
          priority if (in_chan.kind == KIND_EVENT) begin
            unique case (ev_type)
              TYPE_MO: begin
                if (in_chan.is_press) layers_nxt = layers_r | ev_bit;
                else                  layers_nxt = layers_r & ~ev_bit_nz;
              end
              TYPE_TG: begin
                if (in_chan.is_press) layers_nxt = layers_r ^ ev_bit_nz;
              end
              TYPE_TO: begin
                if (in_chan.is_press) layers_nxt = MASK_RESET | ev_bit;
              end
              TYPE_TT: begin
                if (in_chan.is_press) begin
                  tap_time_nxt = in_chan.now_ms;
                  if (tap_hit) begin
                    // second tap in time: toggle and restart the count
                    if (tap_cnt_inc >= TAPC_W'(2)) begin
                      layers_nxt  = layers_r ^ ev_bit_nz;
                      tap_cnt_nxt = '0;
                    end else begin
                      tap_cnt_nxt = tap_cnt_inc;
                    end
                  end else begin
                    tap_cnt_nxt   = TAPC_W'(1);
                    tap_layer_nxt = ev_layer;
                    layers_nxt    = layers_r | ev_bit;
                  end
                end
              end
              default: res_pass_nxt = 1'b1;
            endcase
          end else if (in_chan.kind == KIND_LOOKUP) begin
            if (addr_ok) begin
              mem_re    = 1'b1;
              state_nxt = S_READ;
            end else begin
              res_code_nxt = no_key_r;
            end
          end else if (in_chan.kind == KIND_WRITE) begin
            mem_we = addr_ok;
          end else begin
            // unused kind: report the mask only
          end
        end
      end

      S_READ: begin
        // fall through only on a transparent entry with an active layer below
        if (rd_data_r == transp_r && cur_layer_r != '0 && below_hi[TOP_W]) begin
          mem_re        = 1'b1;
          mem_addr      = map_addr(LAYER_W'(below_hi[TOP_W-1:0]), row_r, col_r);
          cur_layer_nxt = LAYER_W'(below_hi[TOP_W-1:0]);
        end else begin
          res_code_nxt = rd_data_r;
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_pass_nxt  = res_pass_r;
          out_code_nxt  = res_code_r;
          out_mask_nxt  = layers_r;
          out_top_nxt   = top_hi[TOP_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      layers_r    <= MASK_RESET;
      tap_time_r  <= '0;
      tap_cnt_r   <= '0;
      tap_layer_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      layers_r    <= layers_nxt;
      tap_time_r  <= tap_time_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      tap_layer_r <= tap_layer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_layer_r <= cur_layer_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    res_pass_r  <= res_pass_nxt;
    res_code_r  <= res_code_nxt;
    out_pass_r  <= out_pass_nxt;
    out_code_r  <= out_code_nxt;
    out_mask_r  <= out_mask_nxt;
    out_top_r   <= out_top_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.not_layer_key = out_pass_r;
  assign out_chan.resolved_code = out_code_r;
  assign out_chan.active_mask   = out_mask_r;
  assign out_chan.top_layer     = out_top_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // read data is only consumed the cycle after a read was issued
  `KLR_ASSERT_NOW(a_read_follows_issue, state_r == S_READ, $past(mem_re),
                  "keymap data used without a read issued")
  // the layer mask holds still while a lookup walks the keymap
  `KLR_ASSERT_NOW(a_mask_stable_walk, state_r == S_READ, $stable(layers_r),
                  "layer mask changed during a lookup")
  // a pending result is not dropped while the output stalls
  `KLR_ASSERT_NEXT(a_result_held, state_r == S_DONE && out_valid_r && !out_chan.ready,
                   state_r == S_DONE, "pending result lost while output stalled")

endmodule

// ----- bench/keymap_layer_resolver_tb.sv -----
// ----------------------------------------------------------------------------
// keymap_layer_resolver_tb
// Self-checking bench for the keymap layer resolver. A short directed table
// covers reset state, layer commands, the tap-toggle window and its time
// wrap, and fall-through over transparent keys. A random part follows over
// several register settings and idle profiles. Every result transaction is
// compared with its typed table row or else with a bench-side model of the layer stack and the keymap.
// ----------------------------------------------------------------------------
module keymap_layer_resolver_tb;
  import klr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused kind
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 4 * (2 + LAYER_COUNT);
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] key_code;
    logic              is_press;
    logic [TIME_W-1:0] now_ms;
    logic [LIDX_W-1:0] layer_index;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_index;
    logic [CODE_W-1:0] entry_value;
  } item_t;

  typedef struct packed {
    logic              not_layer_key;
    logic [CODE_W-1:0] resolved_code;
    logic [MASK_W-1:0] active_mask;
    logic [TOP_W-1:0]  top_layer;
  } result_t;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  klr_in_if  in_chan ();
  klr_out_if out_chan ();

  keymap_layer_resolver uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Model state: layer stack, tap-toggle bookkeeping, keymap and registers.
  // keymap_valid marks entries written so far; lookups that would touch an
  // unwritten entry are never sent.
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0] layer_mask;
  logic [TIME_W-1:0] tap_stamp;
  logic [TAPC_W-1:0] tap_hits;
  logic [LIDX_W-1:0] tap_target;
  bit   [CODE_W-1:0] keymap_mem   [DEPTH];
  bit                keymap_valid [DEPTH];
  logic [CODE_W-1:0] tap_term;
  logic [CODE_W-1:0] transp_code;
  logic [CODE_W-1:0] nokey_code;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];

  // stimulus shaping
  logic [TIME_W-1:0] ms_clock;
  logic [LIDX_W-1:0] last_tt_layer;
  int send_idle_pct;
  int recv_stall_pct;

  // bookkeeping
  int fail_count;
  int cycle_count;
  int n_checked;
  int n_events;
  int n_lookups;
  int n_writes;
  int n_spare;
  int n_double_taps;
  int n_settings;

  always #10 clk = ~clk;

  // Run-away guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL keymap_layer_resolver");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned key_addr(input int unsigned lyr, input int unsigned r,
                                           input int unsigned c);
    return (lyr * ROW_COUNT + r) * COL_COUNT + c;
  endfunction

  function automatic bit addr_in_range(input item_t it);
    return it.layer_index < LAYER_COUNT && it.row_index < ROW_COUNT &&
           it.col_index < COL_COUNT;
  endfunction

  function automatic void raise_layer(input logic [LIDX_W-1:0] lyr);
    if (lyr < LAYER_COUNT) layer_mask[lyr] = 1'b1;
  endfunction

  // layer 0 can never be flipped off
  function automatic void flip_layer(input logic [LIDX_W-1:0] lyr);
    if (lyr < LAYER_COUNT && lyr != 0) layer_mask[lyr] = ~layer_mask[lyr];
  endfunction

  function automatic logic [TOP_W-1:0] top_of(input logic [MASK_W-1:0] m);
    for (int i = LAYER_COUNT - 1; i >= 0; i--)
      if (m[i]) return TOP_W'(i);
    return '0;
  endfunction

  // Keymap read with transparent fall-through to lower active layers. The
  // layer looked up itself need not be active. known drops to 0 if any
  // entry on the walk was never written; hole gives the first such entry.
  function automatic logic [CODE_W-1:0] keymap_walk(input item_t it, output bit known,
                                                    output int unsigned hole);
    logic [CODE_W-1:0] code;
    int unsigned a;
    int i;
    known = 1'b1;
    hole  = 0;
    if (!addr_in_range(it)) return nokey_code;
    a = key_addr(it.layer_index, it.row_index, it.col_index);
    if (!keymap_valid[a]) begin
      known = 1'b0;
      hole  = a;
    end
    code = keymap_mem[a];
    if (code == transp_code && it.layer_index > 0) begin
      for (i = int'(it.layer_index); i > 0; i--) begin
        if (layer_mask[i-1]) begin
          a = key_addr(i - 1, it.row_index, it.col_index);
          if (!keymap_valid[a] && known) begin
            known = 1'b0;
            hole  = a;
          end
          code = keymap_mem[a];
          if (code != transp_code) break;
        end
      end
    end
    return code;
  endfunction

  // Layer command decode; returns 1 when the keycode is not a layer command.
  function automatic logic apply_layer_event(input item_t it);
    logic [7:0]        typ;
    logic [LIDX_W-1:0] lyr;
    logic [TIME_W-1:0] elapsed;
    typ = it.key_code[15:8];
    lyr = it.key_code[7:0];
    case (typ)
      TYPE_MO: begin
        if (it.is_press) raise_layer(lyr);
        else if (lyr < LAYER_COUNT && lyr != 0) layer_mask[lyr] = 1'b0;
      end
      TYPE_TG: begin
        if (it.is_press) flip_layer(lyr);
      end
      TYPE_TO: begin
        if (it.is_press) begin
          layer_mask = MASK_RESET;
          raise_layer(lyr);
        end
      end
      TYPE_TT: begin
        // second tap of the same layer inside the window toggles it;
        // elapsed time wraps at 32 bits
        if (it.is_press) begin
          elapsed = it.now_ms - tap_stamp;
          if (elapsed < TIME_W'(tap_term) && tap_target == lyr) begin
            tap_hits = tap_hits + 2'd1;
            if (tap_hits >= 2) begin
              flip_layer(lyr);
              tap_hits = '0;
              n_double_taps++;
            end
          end else begin
            tap_hits   = 2'd1;
            tap_target = lyr;
            raise_layer(lyr);
          end
          tap_stamp = it.now_ms;
        end
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  // One result per item; updates the model state.
  function automatic result_t resolve_item(input item_t it);
    result_t res;
    bit known;
    int unsigned hole;
    res = '0;
    case (it.kind)
      KIND_EVENT: begin
        res.not_layer_key = apply_layer_event(it);
        n_events++;
      end
      KIND_LOOKUP: begin
        res.resolved_code = keymap_walk(it, known, hole);
        n_lookups++;
      end
      KIND_WRITE: begin
        if (addr_in_range(it)) begin
          keymap_mem[key_addr(it.layer_index, it.row_index, it.col_index)] =
            it.entry_value;
          keymap_valid[key_addr(it.layer_index, it.row_index, it.col_index)] = 1'b1;
        end
        n_writes++;
      end
      default: n_spare++;
    endcase
    res.active_mask = layer_mask;
    res.top_layer   = top_of(layer_mask);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic item_t mk_item(input logic [KIND_W-1:0] kind,
                                    input logic [CODE_W-1:0] code, input logic press,
                                    input logic [TIME_W-1:0] now,
                                    input logic [LIDX_W-1:0] lyr,
                                    input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                    input logic [CODE_W-1:0] val);
    return '{kind, code, press, now, lyr, r, c, val};
  endfunction

  function automatic result_t mk_res(input logic nlk, input logic [CODE_W-1:0] rc,
                                     input logic [MASK_W-1:0] m,
                                     input logic [TOP_W-1:0] top);
    return '{nlk, rc, m, top};
  endfunction

  function automatic void add_dir(input item_t s, input bit typed, input result_t w);
    dir_rows.push_back('{s, typed, w});
  endfunction

  // Mostly a few hot keys so writes and lookups meet; sometimes anywhere,
  // sometimes a layer beyond the keymap.
  function automatic item_t with_address(input item_t it);
    item_t o;
    o = it;
    if ($urandom_range(0, 99) < 5) o.layer_index = LIDX_W'($urandom_range(LAYER_COUNT, 255));
    else o.layer_index = LIDX_W'($urandom_range(0, LAYER_COUNT - 1));
    if ($urandom_range(0, 99) < 80) o.row_index = ROW_W'($urandom_range(0, 1));
    else o.row_index = ROW_W'($urandom_range(0, ROW_COUNT - 1));
    if ($urandom_range(0, 99) < 80) o.col_index = COL_W'($urandom_range(0, 3));
    else o.col_index = COL_W'($urandom_range(0, COL_COUNT - 1));
    return o;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    int r;
    logic [7:0] typ;
    logic [LIDX_W-1:0] lyr;
    bit known;
    int unsigned hole;
    logic [CODE_W-1:0] dummy;
    // unused fields carry random bits as well
    it.key_code    = CODE_W'($urandom);
    it.is_press    = 1'($urandom);
    it.now_ms      = $urandom;
    it.layer_index = LIDX_W'($urandom);
    it.row_index   = ROW_W'($urandom);
    it.col_index   = COL_W'($urandom);
    it.entry_value = CODE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.kind = KIND_EVENT;
      typ = 8'h00;
      if ($urandom_range(0, 99) < 15) begin
        it.key_code = CODE_W'($urandom);   // mostly not a layer command
      end else begin
        case ($urandom_range(0, 4))
          0:       typ = TYPE_MO;
          1:       typ = TYPE_TG;
          2:       typ = TYPE_TO;
          default: typ = TYPE_TT;
        endcase
        if ($urandom_range(0, 99) < 8) lyr = LIDX_W'($urandom_range(LAYER_COUNT, 255));
        else if (typ == TYPE_TT && $urandom_range(0, 99) < 60) lyr = last_tt_layer;
        else lyr = LIDX_W'($urandom_range(0, LAYER_COUNT - 1));
        if (typ == TYPE_TT) last_tt_layer = lyr;
        it.key_code = {typ, lyr};
      end
      it.is_press = ($urandom_range(0, 99) < ((typ == TYPE_MO) ? 50 : 75));
      // time stamps: mostly inside or just past the tap window
      r = $urandom_range(0, 99);
      if (r < 8)       ms_clock = $urandom;
      else if (r < 11) ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 100);
      else if (r < 60) ms_clock = ms_clock + $urandom_range(0, tap_term);
      else if (r < 85) ms_clock = ms_clock + TIME_W'(tap_term) + $urandom_range(0, 50);
      else             ms_clock = ms_clock + $urandom_range(0, 5000);
      it.now_ms = ms_clock;
    end else if (pick < 65) begin
      it = with_address(it);
      it.kind = KIND_LOOKUP;
      dummy = keymap_walk(it, known, hole);
      // the walk would hit a never-written entry: fill that entry instead
      if (!known) begin
        it.kind        = KIND_WRITE;
        it.layer_index = LIDX_W'(hole / (ROW_COUNT * COL_COUNT));
        it.row_index   = ROW_W'((hole / COL_COUNT) % ROW_COUNT);
        it.col_index   = COL_W'(hole % COL_COUNT);
        it.entry_value = ($urandom_range(0, 99) < 40) ? transp_code : CODE_W'($urandom);
      end
    end else if (pick < 95) begin
      it = with_address(it);
      it.kind = KIND_WRITE;
      r = $urandom_range(0, 99);
      if (r < 40)      it.entry_value = transp_code;
      else if (r < 50) it.entry_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      it.kind = KIND_SPARE;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optional idle gap, then hold the transaction until accepted.
  // valid is only lowered when a gap follows, so it never toggles twice in
  // one step.
  // --------------------------------------------------------------------------
  task automatic drive_item(input item_t it, input result_t want);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= it.kind;
    in_chan.key_code    <= it.key_code;
    in_chan.is_press    <= it.is_press;
    in_chan.now_ms      <= it.now_ms;
    in_chan.layer_index <= it.layer_index;
    in_chan.row_index   <= it.row_index;
    in_chan.col_index   <= it.col_index;
    in_chan.entry_value <= it.entry_value;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_results.push_back(want);
  endtask

  // Register write (setup + access), then read back the same register.
  task automatic cfg_write(input logic [1:0] idx, input logic [CODE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands at this edge; start the read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("prdata", 32'(val), 32'(prdata[CODE_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TAP_TERM: tap_term    = val;
      REG_TRANSP:   transp_code = val;
      default:      nokey_code  = val;
    endcase
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 80 : (mode == IDLE_BOTH) ? 34 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 80 : (mode == IDLE_BOTH) ? 34 : 0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted result against the oldest expectation,
  // then pick ready for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("not_layer_key", 32'(want.not_layer_key), 32'(out_chan.not_layer_key));
        check_field("resolved_code", 32'(want.resolved_code), 32'(out_chan.resolved_code));
        check_field("active_mask", 32'(want.active_mask), 32'(out_chan.active_mask));
        check_field("top_layer", 32'(want.top_layer), 32'(out_chan.top_layer));
        n_checked++;
      end
    end
    out_chan.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    item_t   it;
    result_t want;
    logic [CODE_W-1:0] term_val;
    logic [CODE_W-1:0] transp_val;
    logic [CODE_W-1:0] nokey_val;
    idle_mode_t mode;

    clk           = 1'b0;
    fail_count    = 0;
    n_checked     = 0;
    n_events      = 0;
    n_lookups     = 0;
    n_writes      = 0;
    n_spare       = 0;
    n_double_taps = 0;
    n_settings    = 1;
    ms_clock      = '0;
    last_tt_layer = '0;
    set_idle(IDLE_NONE);

    // model reset state
    layer_mask  = MASK_RESET;
    tap_stamp   = '0;
    tap_hits    = '0;
    tap_target  = '0;
    tap_term    = TAP_TERM_RESET;
    transp_code = TRANSP_RESET;
    nokey_code  = NO_KEY_RESET;

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.kind        <= '0;
    in_chan.key_code    <= '0;
    in_chan.is_press    <= 1'b0;
    in_chan.now_ms      <= '0;
    in_chan.layer_index <= '0;
    in_chan.row_index   <= '0;
    in_chan.col_index   <= '0;
    in_chan.entry_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, reset register values (term 200, transparent 1,
    // no-key 0). Typed results are read straight off the behavior.
    // unused kind with every field at all ones: mask only
    add_dir(mk_item(KIND_SPARE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 3'd7, 4'd15, 16'hFFFF),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // lookup beyond the layer count gives the no-key code
    add_dir(mk_item(KIND_LOOKUP, 16'h0000, 1'b0, 32'd0, 8'hFF, 3'd7, 4'd15, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    add_dir(mk_item(KIND_WRITE, 16'h0000, 1'b0, 32'd0, 8'd0, 3'd0, 4'd0, 16'hFFFF),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    add_dir(mk_item(KIND_WRITE, 16'h0000, 1'b0, 32'd0, 8'd1, 3'd0, 4'd0, 16'h0001),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    add_dir(mk_item(KIND_WRITE, 16'h0000, 1'b0, 32'd0, 8'd7, 3'd0, 4'd0, 16'h0001),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // write beyond the layer count is dropped
    add_dir(mk_item(KIND_WRITE, 16'h0000, 1'b0, 32'd0, 8'h80, 3'd0, 4'd0, 16'h1234),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    add_dir(mk_item(KIND_LOOKUP, 16'h0000, 1'b0, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'hFFFF, 8'h01, 3'd0));
    // inactive top layer, transparent: falls straight to layer 0
    add_dir(mk_item(KIND_LOOKUP, 16'h0000, 1'b0, 32'd0, 8'd7, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'hFFFF, 8'h01, 3'd0));
    // momentary layer: press, out of range, plain key, release
    add_dir(mk_item(KIND_EVENT, 16'h5107, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h81, 3'd7));
    add_dir(mk_item(KIND_EVENT, 16'h5108, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h81, 3'd7));
    add_dir(mk_item(KIND_EVENT, 16'h0004, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b1, 16'h0000, 8'h81, 3'd7));
    add_dir(mk_item(KIND_EVENT, 16'h5107, 1'b0, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // toggle layer 1, then walk 7 -> 1 (transparent) -> 0
    add_dir(mk_item(KIND_EVENT, 16'h5201, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h03, 3'd1));
    add_dir(mk_item(KIND_LOOKUP, 16'h0000, 1'b0, 32'd0, 8'd7, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'hFFFF, 8'h03, 3'd1));
    add_dir(mk_item(KIND_EVENT, 16'h5201, 1'b0, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h03, 3'd1));
    // layer zero cannot be toggled off
    add_dir(mk_item(KIND_EVENT, 16'h5200, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h03, 3'd1));
    // TO; out-of-range TO still clears to layer 0
    add_dir(mk_item(KIND_EVENT, 16'h5305, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h21, 3'd5));
    add_dir(mk_item(KIND_EVENT, 16'h53FF, 1'b1, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // tap-toggle: first tap sets, quick second tap flips off, release no-op
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b1, 32'd1000, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h05, 3'd2));
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b1, 32'd1100, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b0, 32'd1150, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // tap window across the 32-bit time wrap
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b1, 32'hFFFF_FFF0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h05, 3'd2));
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b1, 32'h0000_0010, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // releasing momentary layer 0 keeps it on
    add_dir(mk_item(KIND_EVENT, 16'h5100, 1'b0, 32'd0, 8'd0, 3'd0, 4'd0, 16'h0000),
            1, mk_res(1'b0, 16'h0000, 8'h01, 3'd0));
    // out-of-range TT still moves the tap bookkeeping
    add_dir(mk_item(KIND_EVENT, 16'h54FF, 1'b1, 32'd20, 8'd0, 3'd0, 4'd0, 16'h0000),
            0, '0);
    add_dir(mk_item(KIND_EVENT, 16'h5402, 1'b1, 32'd40, 8'd0, 3'd0, 4'd0, 16'h0000),
            0, '0);

    foreach (dir_rows[i]) begin
      want = resolve_item(dir_rows[i].stim);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      drive_item(dir_rows[i].stim, want);
    end
    in_chan.valid <= 1'b0;
    ms_clock = 32'd40;

    // Random phases: registers rewritten while idle, idle profile changes.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin term_val = 16'hFFFF; transp_val = 16'h0001; nokey_val = 16'hFFFF;
                 mode = IDLE_NONE; end
        1: begin term_val = 16'h0000; transp_val = 16'h0000; nokey_val = 16'h0000;
                 mode = IDLE_SEND; end
        2: begin term_val = 16'd30;   transp_val = 16'hFFFF; nokey_val = 16'h5A5A;
                 mode = IDLE_RECV; end
        3: begin term_val = 16'd200;  transp_val = 16'h0001; nokey_val = 16'h0001;
                 mode = IDLE_BOTH; end
        4: begin term_val = 16'd1;    transp_val = 16'h00FF; nokey_val = 16'hA5A5;
                 mode = IDLE_NONE; end
        default: begin
          term_val   = CODE_W'($urandom_range(1, 400));
          transp_val = CODE_W'($urandom);
          nokey_val  = CODE_W'($urandom);
          mode       = IDLE_BOTH;
        end
      endcase
      cfg_write(REG_TAP_TERM, term_val);
      cfg_write(REG_TRANSP, transp_val);
      cfg_write(REG_NO_KEY, nokey_val);
      n_settings++;
      set_idle(mode);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it   = random_item();
        want = resolve_item(it);
        drive_item(it, want);
      end
      in_chan.valid <= 1'b0;
    end

    // drain, then give a stray result time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d layer events (%0d tap-toggle flips), %0d lookups,",
             n_checked, n_events, n_double_taps, n_lookups);
    $display("%0d keymap writes, %0d unused-kind items over %0d register settings",
             n_writes, n_spare, n_settings);
    if (fail_count == 0) begin
      $display("PASS keymap_layer_resolver");
    end else begin
      $display("FAIL keymap_layer_resolver");
    end
    $finish;
  end

endmodule
